### sv/assert_macros.svh
// Assertion helpers for the checker in sv/uwdb_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define CHK_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define CHK_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/uwdb_pkg.sv
package uwdb_pkg;

    localparam int BYTE_W     = 8;
    localparam int ADDR_W     = 7;
    localparam int VALUE_W    = 32;
    localparam int IN_DATA_W  = 40;
    localparam int DGRAM_LEN  = 8;
    localparam int BEAT_CNT_W = 3;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    localparam logic [BYTE_W-1:0]     SYNC_BYTE  = 8'h05;
    localparam logic [BYTE_W-1:0]     WRITE_FLAG = 8'h80;
    localparam logic [BYTE_W-1:0]     CRC_POLY   = 8'h07;
    localparam logic [BEAT_CNT_W-1:0] LAST_BEAT  = 3'd7;
    localparam logic [PADDR_W-1:0]    ADDR_NODE  = 3'd0;

    localparam logic [BYTE_W-1:0] NODE_ADDRESS_RESET = 8'h00;

    // One datagram on its way through the CRC stages.
    typedef struct packed {
        logic [BYTE_W-1:0]  node;
        logic [BYTE_W-1:0]  addr;
        logic [VALUE_W-1:0] value;
        logic [BYTE_W-1:0]  crc;
    } dgram_t;

    // CRC8 update over one byte, data bits taken least significant first.
    function automatic logic [BYTE_W-1:0] crc8_update(
        input logic [BYTE_W-1:0] acc,
        input logic [BYTE_W-1:0] data
    );
        logic [BYTE_W-1:0] c;
        c = acc;
        for (int i = 0; i < BYTE_W; i++)
        begin
            if (c[BYTE_W-1] ^ data[i])
                c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[BYTE_W-2:0], 1'b0};
        end
        return c;
    endfunction

    // The sync byte never changes, so its CRC contribution is fixed.
    localparam logic [BYTE_W-1:0] CRC_AFTER_SYNC = crc8_update(8'h00, SYNC_BYTE);

endpackage

### sv/uart_write_datagram_builder_unit.sv
// Channel   Dir  Width  Contents
// s_axis    in   40     register write request: reg_address, reg_value
// m_axis    out  8      datagram bytes in wire order, tlast on the CRC byte
// apb       in   3/32   node_address at byte address 0
//
// Each request yields eight bytes, one per cycle on m_axis while m_axis_tready
// is high; the one-byte output serializer takes the next request as the CRC byte leaves.
// After acceptance a request passes three CRC stages, then loads the serializer.
// Reset clears all valid bits, the serializer's busy flag and counter, and node_address.
// With m_axis_tready low the current byte holds; the stages keep up to three
// more requests before s_axis_tready drops.
module uart_write_datagram_builder_unit
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [uwdb_pkg::IN_DATA_W-1:0]       s_axis_tdata,  // reg_address[6:0], reg_value[38:7], pad
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [uwdb_pkg::BYTE_W-1:0]          m_axis_tdata,  // tx_byte[7:0]
    output logic                                 m_axis_tlast,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [uwdb_pkg::PADDR_W-1:0]         paddr,
    input  logic [uwdb_pkg::PDATA_W-1:0]         pwdata,
    output logic [uwdb_pkg::PDATA_W-1:0]         prdata,
    output logic                                 pready
);

    logic [uwdb_pkg::BYTE_W-1:0] node_address_reg;

    uwdb_pkg::dgram_t s0_data;
    uwdb_pkg::dgram_t s1_data;
    uwdb_pkg::dgram_t s2_data;
    uwdb_pkg::dgram_t s3_data;
    logic             s1_valid;
    logic             s1_ready;
    logic             s2_valid;
    logic             s2_ready;
    logic             s3_valid;
    logic             s3_ready;

    // Configuration
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            node_address_reg <= uwdb_pkg::NODE_ADDRESS_RESET;
        else if (psel && penable && pwrite && pready && (paddr == uwdb_pkg::ADDR_NODE))
            node_address_reg <= pwdata[uwdb_pkg::BYTE_W-1:0];
    end

    always_comb
    begin
        prdata = '0;
        if (paddr == uwdb_pkg::ADDR_NODE)
            prdata = {{(uwdb_pkg::PDATA_W-uwdb_pkg::BYTE_W){1'b0}}, node_address_reg};
    end

    // Build the request's datagram fields; the sync byte is already in the CRC.
    always_comb
    begin
        s0_data.node  = node_address_reg;
        s0_data.addr  = {1'b0, s_axis_tdata[uwdb_pkg::ADDR_W-1:0]} | uwdb_pkg::WRITE_FLAG;
        s0_data.value = s_axis_tdata[uwdb_pkg::ADDR_W +: uwdb_pkg::VALUE_W];
        s0_data.crc   = uwdb_pkg::CRC_AFTER_SYNC;
    end

    uwdb_crc_stage u_stage1
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (s0_data),
        .byte_a    (s0_data.node),
        .byte_b    (s0_data.addr),
        .out_valid (s1_valid),
        .out_ready (s1_ready),
        .out_data  (s1_data)
    );

    uwdb_crc_stage u_stage2
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid),
        .in_ready  (s1_ready),
        .in_data   (s1_data),
        .byte_a    (s1_data.value[31:24]),
        .byte_b    (s1_data.value[23:16]),
        .out_valid (s2_valid),
        .out_ready (s2_ready),
        .out_data  (s2_data)
    );

    uwdb_crc_stage u_stage3
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid),
        .in_ready  (s2_ready),
        .in_data   (s2_data),
        .byte_a    (s2_data.value[15:8]),
        .byte_b    (s2_data.value[7:0]),
        .out_valid (s3_valid),
        .out_ready (s3_ready),
        .out_data  (s3_data)
    );

    uwdb_serializer u_ser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s3_valid),
        .in_ready  (s3_ready),
        .in_data   (s3_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_byte  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule

### sv/uwdb_crc_stage.sv
module uwdb_crc_stage
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  uwdb_pkg::dgram_t            in_data,
    input  logic [uwdb_pkg::BYTE_W-1:0] byte_a,
    input  logic [uwdb_pkg::BYTE_W-1:0] byte_b,
    output logic                        out_valid,
    input  logic                        out_ready,
    output uwdb_pkg::dgram_t            out_data
);

    logic             valid_reg;
    uwdb_pkg::dgram_t data_reg;
    uwdb_pkg::dgram_t data_next;

    assign in_ready = !valid_reg || out_ready;

    // Fold two datagram bytes, in transmit order, into the running CRC.
    always_comb
    begin
        data_next     = in_data;
        data_next.crc = uwdb_pkg::crc8_update(uwdb_pkg::crc8_update(in_data.crc, byte_a),
                                              byte_b);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

### sv/uwdb_serializer.sv
module uwdb_serializer
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  uwdb_pkg::dgram_t            in_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [uwdb_pkg::BYTE_W-1:0] out_byte,
    output logic                        out_last
);

    localparam int SHIFT_W = uwdb_pkg::BYTE_W * uwdb_pkg::DGRAM_LEN;

    logic                              busy_reg;
    logic [uwdb_pkg::BEAT_CNT_W-1:0]   cnt_reg;
    logic [SHIFT_W-1:0]                shift_reg;
    logic [SHIFT_W-1:0]                load_bytes;
    logic                              at_last;
    logic                              load;

    assign at_last  = (cnt_reg == uwdb_pkg::LAST_BEAT);
    assign in_ready = !busy_reg || (out_ready && at_last);
    assign load     = in_valid && in_ready;

    // First byte on the wire sits in the lowest bits.
    assign load_bytes = {in_data.crc,
                         in_data.value[7:0],
                         in_data.value[15:8],
                         in_data.value[23:16],
                         in_data.value[31:24],
                         in_data.addr,
                         in_data.node,
                         uwdb_pkg::SYNC_BYTE};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (load)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg && out_ready)
        begin
            if (at_last)
                busy_reg <= 1'b0;
            else
                cnt_reg <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            shift_reg <= load_bytes;
        else if (busy_reg && out_ready)
            shift_reg <= {{uwdb_pkg::BYTE_W{1'b0}}, shift_reg[SHIFT_W-1:uwdb_pkg::BYTE_W]};
    end

    assign out_valid = busy_reg;
    assign out_byte  = shift_reg[uwdb_pkg::BYTE_W-1:0];
    assign out_last  = at_last;

endmodule

### sv/uwdb_checker.sv
`include "assert_macros.svh"

module uwdb_checker
(
    input logic                           clk,
    input logic                           rst_n,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [uwdb_pkg::BYTE_W-1:0]    m_axis_tdata,
    input logic                           m_axis_tlast
);

    logic [uwdb_pkg::BEAT_CNT_W-1:0] beat_reg;
    logic [uwdb_pkg::BEAT_CNT_W-1:0] beat_next;
    logic                            first_beat;
    logic                            sync_seen;
    logic                            last_ok;
    logic                            stalled;

    // Track the byte position within the current datagram.
    always_comb
    begin
        beat_next = beat_reg;
        if (m_axis_tvalid && m_axis_tready)
            beat_next = beat_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            beat_reg <= '0;
        else
            beat_reg <= beat_next;
    end

    assign first_beat = m_axis_tvalid && (beat_reg == '0);
    assign sync_seen  = (m_axis_tdata == uwdb_pkg::SYNC_BYTE);
    assign last_ok    = (m_axis_tlast == (beat_reg == uwdb_pkg::LAST_BEAT));
    assign stalled    = m_axis_tvalid && !m_axis_tready;

    `CHK_ASSERT(a_sync_first, first_beat |-> sync_seen, "datagram does not open with sync byte")
    `CHK_ASSERT(a_last_eighth, m_axis_tvalid |-> last_ok, "tlast not on eighth byte")
    `CHK_ASSERT(a_hold_valid, stalled |=> m_axis_tvalid, "output request dropped while stalled")
    `CHK_ASSERT(a_hold_byte, stalled |=> $stable({m_axis_tdata, m_axis_tlast}), "stalled byte changed")
    `CHK_ASSERT_ALWAYS(a_reset_idle, !rst_n |-> !m_axis_tvalid, "output valid during reset")

endmodule

bind uart_write_datagram_builder_unit uwdb_checker u_uwdb_checker (.*);

### dv/uwdb_checker.sv
`timescale 1ns / 100ps

module uwdb_scoreboard
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    input  logic                           s_axis_tready,
    input  logic [uwdb_pkg::IN_DATA_W-1:0] s_axis_tdata,  // reg_address[6:0], reg_value[38:7], pad
    input  logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    input  logic [uwdb_pkg::BYTE_W-1:0]    m_axis_tdata,  // tx_byte[7:0]
    input  logic                           m_axis_tlast,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [uwdb_pkg::PADDR_W-1:0]   paddr,
    input  logic [uwdb_pkg::PDATA_W-1:0]   pwdata,
    input  logic [uwdb_pkg::PDATA_W-1:0]   prdata,
    input  logic                           pready,
    output int                             error_count,
    output int                             pending_bytes
);

    localparam int PAD_W = uwdb_pkg::PDATA_W - uwdb_pkg::BYTE_W;

    typedef struct packed {
        logic [uwdb_pkg::BYTE_W-1:0] tx_byte;
        logic                        last_byte;
    } wire_byte_t;

    wire_byte_t                  wire_bytes_q[$];
    logic [uwdb_pkg::BYTE_W-1:0] node_shadow;

    // CRC8 over one byte, data bits fed least significant first
    function automatic logic [uwdb_pkg::BYTE_W-1:0] crc_fold(
        input logic [uwdb_pkg::BYTE_W-1:0] acc,
        input logic [uwdb_pkg::BYTE_W-1:0] data
    );
        logic [uwdb_pkg::BYTE_W-1:0] c;
        logic                        feedback;
        c = acc;
        for (int i = 0; i < uwdb_pkg::BYTE_W; i++)
        begin
            feedback = c[uwdb_pkg::BYTE_W-1] ^ data[i];
            c = {c[uwdb_pkg::BYTE_W-2:0], 1'b0};
            if (feedback)
                c = c ^ uwdb_pkg::CRC_POLY;
        end
        return c;
    endfunction

    function automatic void queue_datagram(
        input logic [uwdb_pkg::ADDR_W-1:0]  reg_addr,
        input logic [uwdb_pkg::VALUE_W-1:0] reg_val
    );
        logic [uwdb_pkg::BYTE_W-1:0] frame [uwdb_pkg::DGRAM_LEN];
        logic [uwdb_pkg::BYTE_W-1:0] crc;
        wire_byte_t                  beat;
        frame[0] = uwdb_pkg::SYNC_BYTE;
        frame[1] = node_shadow;
        frame[2] = {1'b0, reg_addr} | uwdb_pkg::WRITE_FLAG;
        frame[3] = reg_val[31:24];
        frame[4] = reg_val[23:16];
        frame[5] = reg_val[15:8];
        frame[6] = reg_val[7:0];
        crc = '0;
        for (int k = 0; k < uwdb_pkg::DGRAM_LEN - 1; k++)
            crc = crc_fold(crc, frame[k]);
        frame[uwdb_pkg::DGRAM_LEN-1] = crc;
        for (int k = 0; k < uwdb_pkg::DGRAM_LEN; k++)
        begin
            beat.tx_byte   = frame[k];
            beat.last_byte = (k == uwdb_pkg::DGRAM_LEN - 1);
            wire_bytes_q.push_back(beat);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        wire_byte_t want;
        int         errs;
        errs = 0;
        if (!rst_n)
        begin
            wire_bytes_q.delete();
            node_shadow = uwdb_pkg::NODE_ADDRESS_RESET;
            error_count   <= 0;
            pending_bytes <= 0;
        end
        else
        begin
            if (psel && penable && pready)
            begin
                if (pwrite)
                begin
                    // writes to any other register index are dropped
                    if (paddr == uwdb_pkg::ADDR_NODE)
                        node_shadow = pwdata[uwdb_pkg::BYTE_W-1:0];
                end
                else if (paddr == uwdb_pkg::ADDR_NODE &&
                         prdata !== {{PAD_W{1'b0}}, node_shadow})
                begin
                    $display("%0t: node_address read mismatch expected %08h actual %08h",
                             $time, {{PAD_W{1'b0}}, node_shadow}, prdata);
                    errs++;
                end
            end

            if (m_axis_tvalid && m_axis_tready)
            begin
                if (wire_bytes_q.size() == 0)
                begin
                    $display("%0t: unexpected byte expected none actual %02h last %0b",
                             $time, m_axis_tdata, m_axis_tlast);
                    errs++;
                end
                else
                begin
                    want = wire_bytes_q.pop_front();
                    if (m_axis_tdata !== want.tx_byte)
                    begin
                        $display("%0t: tx_byte mismatch expected %02h actual %02h",
                                 $time, want.tx_byte, m_axis_tdata);
                        errs++;
                    end
                    if (m_axis_tlast !== want.last_byte)
                    begin
                        $display("%0t: last_byte mismatch expected %0b actual %0b",
                                 $time, want.last_byte, m_axis_tlast);
                        errs++;
                    end
                end
            end

            if (s_axis_tvalid && s_axis_tready)
                queue_datagram(s_axis_tdata[uwdb_pkg::ADDR_W-1:0],
                               s_axis_tdata[uwdb_pkg::ADDR_W +: uwdb_pkg::VALUE_W]);

            error_count   <= error_count + errs;
            pending_bytes <= wire_bytes_q.size();
        end
    end

endmodule

### dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    // register index 4 does not exist
    localparam logic [uwdb_pkg::PADDR_W-1:0] ADDR_SPARE = 3'd4;

    logic                           clk;
    logic                           rst_n;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    logic [uwdb_pkg::IN_DATA_W-1:0] s_axis_tdata;   // reg_address[6:0], reg_value[38:7], pad
    logic                           m_axis_tvalid;
    logic                           m_axis_tready;
    logic [uwdb_pkg::BYTE_W-1:0]    m_axis_tdata;   // tx_byte[7:0]
    logic                           m_axis_tlast;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [uwdb_pkg::PADDR_W-1:0]   paddr;
    logic [uwdb_pkg::PDATA_W-1:0]   pwdata;
    logic [uwdb_pkg::PDATA_W-1:0]   prdata;
    logic                           pready;
    int                             error_count;
    int                             pending_bytes;
    bit                             no_idle;

    uart_write_datagram_builder_unit dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    uwdb_scoreboard u_scoreboard
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .error_count   (error_count),
        .pending_bytes (pending_bytes)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
        m_axis_tready <= no_idle || ($urandom_range(99) >= 8);

    initial
    begin
        #400000;
        $display("Verification failed");
        $finish;
    end

    task automatic send_request(
        input logic [uwdb_pkg::ADDR_W-1:0]  reg_addr,
        input logic [uwdb_pkg::VALUE_W-1:0] reg_val,
        input logic                         pad
    );
        int gap;
        gap = 0;
        if (!no_idle)
            while ($urandom_range(99) < 8)
                gap++;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {pad, reg_val, reg_addr};
        do @(posedge clk); while (!s_axis_tready);
    endtask

    task automatic send_random_request();
        logic [uwdb_pkg::ADDR_W-1:0]  a;
        logic [uwdb_pkg::VALUE_W-1:0] v;
        int                           rnd;
        case ($urandom_range(9))
            0:       a = '0;
            1:       a = '1;
            default:
            begin
                rnd = $urandom_range(127);
                a   = rnd[uwdb_pkg::ADDR_W-1:0];
            end
        endcase
        case ($urandom_range(9))
            0:       v = '0;
            1:       v = '1;
            2:       v = 32'h1 << $urandom_range(31);
            default: v = $urandom;
        endcase
        rnd = $urandom_range(1);
        send_request(a, v, rnd[0]);
    endtask

    // hold the source low until every queued byte has left the block
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_bytes != 0)
            @(posedge clk);
    endtask

    task automatic apb_write(
        input logic [uwdb_pkg::PADDR_W-1:0] addr,
        input logic [uwdb_pkg::PDATA_W-1:0] data
    );
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apb_read(input logic [uwdb_pkg::PADDR_W-1:0] addr);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_node(input logic [uwdb_pkg::BYTE_W-1:0] node);
        logic [uwdb_pkg::PDATA_W-1:0] noise;
        noise = $urandom;
        // upper write bits carry noise, the register keeps only the low byte
        apb_write(uwdb_pkg::ADDR_NODE,
                  {noise[uwdb_pkg::PDATA_W-1:uwdb_pkg::BYTE_W], node});
        apb_read(uwdb_pkg::ADDR_NODE);
    endtask

    initial
    begin
        int node_rnd;
        clk           = 1'b0;
        rst_n         = 1'b0;
        no_idle       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // node address straight out of reset
        apb_read(uwdb_pkg::ADDR_NODE);
        send_request('0, '0, 1'b0);
        send_request('1, '1, 1'b1);
        send_request(7'h00, 32'hFFFF_FFFF, 1'b0);
        send_request(7'h7F, 32'h0000_0000, 1'b1);
        send_request(7'h55, 32'h8000_0000, 1'b0);
        send_request(7'h2A, 32'h0000_0001, 1'b0);
        send_request(7'h01, 32'h5A5A_A5A5, 1'b1);
        send_request(7'h40, 32'h1234_5678, 1'b0);
        wait_drained();

        set_node(8'hFF);
        send_request('0, 32'hA5A5_5A5A, 1'b0);
        send_request('1, 32'hDEAD_BEEF, 1'b1);
        send_request(7'h3C, 32'h0F0F_F0F0, 1'b0);
        send_request(7'h12, 32'hFFFF_0000, 1'b1);
        wait_drained();

        // write to a register that does not exist, node address must stay
        apb_write(ADDR_SPARE, 32'h0000_003C);
        apb_read(uwdb_pkg::ADDR_NODE);
        set_node(8'h00);
        send_request(7'h6B, 32'h0000_FFFF, 1'b0);
        send_request(7'h7F, 32'hFFFF_FFFF, 1'b1);
        wait_drained();
        node_rnd = $urandom_range(255);
        set_node(node_rnd[uwdb_pkg::BYTE_W-1:0]);
        send_request(7'h00, 32'h0000_0000, 1'b0);
        send_request(7'h10, 32'h0000_00FF, 1'b1);
        wait_drained();

        for (int phase = 0; phase < 4; phase++)
        begin
            node_rnd = $urandom_range(255);
            case (phase)
                0:       set_node(8'hFF);
                1:       set_node(8'h00);
                default: set_node(node_rnd[uwdb_pkg::BYTE_W-1:0]);
            endcase
            no_idle = (phase == 1);
            for (int i = 0; i < 45; i++)
            begin
                if (phase == 2 && i == 20)
                    wait_drained();
                send_random_request();
            end
            wait_drained();
            no_idle = 1'b0;
        end

        repeat (2 * uwdb_pkg::DGRAM_LEN) @(posedge clk);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

### uart_write_datagram_builder_unit.f
+incdir+sv
sv/uwdb_pkg.sv
sv/uwdb_crc_stage.sv
sv/uwdb_serializer.sv
sv/uart_write_datagram_builder_unit.sv
sv/uwdb_checker.sv
dv/uwdb_checker.sv
dv/tb_top.sv
